### rtl/trook_pkg.sv
// types, constants and helpers shared by the tri-state ook encoder files
`timescale 1ns / 1ps

package trook_pkg;

    localparam int unsigned SYMBOLS     = 12;
    localparam int unsigned PULSE_W     = 16;
    localparam int unsigned REPEAT_W    = 8;
    localparam int unsigned PROTO_W     = 2;
    localparam int unsigned UNIT_W      = 5;
    localparam int unsigned SYM_IDX_W   = 4;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam logic [UNIT_W-1:0] SYNC_LONG  = 5'd31;
    localparam logic [UNIT_W-1:0] SYNC_SHORT = 5'd10;
    localparam logic [UNIT_W-1:0] LONG_UNITS = 5'd3;
    localparam logic [UNIT_W-1:0] ONE_UNIT   = 5'd1;

    localparam logic [SYM_IDX_W-1:0] SYNC_INDEX = 4'd12;

    localparam logic [PROTO_W-1:0] PROTO_SHORT_SYNC = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL     = 2'd2;

    localparam logic [PULSE_W-1:0]  PULSE_RESET  = 16'd350;
    localparam logic [REPEAT_W-1:0] REPEAT_RESET = 8'd10;
    localparam logic [PROTO_W-1:0]  PROTO_RESET  = 2'd1;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic rejected;
    } t_result;

    // four symbols, all F (1) except symbol n-1 which is 0
    function automatic logic [3:0] group_bits(input logic [1:0] n);
        logic [1:0] pos;
        logic [3:0] bits;
        pos  = n - 2'd1;
        bits = 4'b1111;
        bits[pos] = 1'b0;
        return bits;
    endfunction

endpackage

### rtl/tristate_ook_remote_switch_encoder_unit.sv
// tri-state ook remote switch encoder: one tick or start command per transaction
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | i_in_valid/o_in_stall| func, address_code, channel_code, switch_on
//  out     | output    | o_out_valid/i_out_stall | pin_level, busy_res, rejected
//  cfg     | input     | i_cfg_we             | i_cfg_index, i_cfg_data
//
// one transaction per cycle unless o_in_stall; its result is registered in r_out or r_skid
// the waveform counters update in the same cycle in a single combinational pass
// a skid register holds one result while the output is stalled; input stalls only when full
// synchronous active-low reset: idle, no results pending, registers at defaults
`timescale 1ns / 1ps

module tristate_ook_remote_switch_encoder_unit
    import trook_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [2:0]            i_address_code,
    input  logic [2:0]            i_channel_code,
    input  logic                  i_switch_on,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_pin_level,
    output logic                  o_busy_res,
    output logic                  o_rejected,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [PULSE_W-1:0]   r_pulse_length;
    logic [REPEAT_W-1:0]  r_repeat_count;
    logic [PROTO_W-1:0]   r_protocol;

    logic [SYMBOLS-1:0]   r_code_word, n_code_word;
    logic [SYM_IDX_W-1:0] r_symbol_index, n_symbol_index;
    logic                 r_pulse_half, n_pulse_half;
    logic                 r_phase_high, n_phase_high;
    logic [UNIT_W-1:0]    r_unit_count, n_unit_count;
    logic [PULSE_W-1:0]   r_tick_count, n_tick_count;
    logic [REPEAT_W-1:0]  r_repeat_done, n_repeat_done;
    logic                 r_active, n_active;

    logic                 r_out_valid;
    t_result              r_out;
    logic                 r_skid_valid;
    t_result              r_skid;

    t_result              n_result;
    logic                 accept;
    logic                 out_free;

    logic                 in_word;
    logic                 cur_sym;
    logic                 long_high;
    logic [UNIT_W-1:0]    phase_len;
    logic [PULSE_W-1:0]   pl;
    logic [REPEAT_W-1:0]  limit;
    logic [PULSE_W-1:0]   tick_inc;
    logic [UNIT_W-1:0]    unit_inc;
    logic [REPEAT_W-1:0]  rd_inc;
    logic                 codes_ok;

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign in_word   = r_symbol_index < SYNC_INDEX;
    assign cur_sym   = in_word ? r_code_word[r_symbol_index] : 1'b0;
    assign long_high = cur_sym && r_pulse_half;
    assign pl        = (r_pulse_length == '0) ? PULSE_W'(1) : r_pulse_length;
    assign limit     = (r_repeat_count == '0) ? REPEAT_W'(1) : r_repeat_count;
    assign tick_inc  = r_tick_count + PULSE_W'(1);
    assign unit_inc  = r_unit_count + UNIT_W'(1);
    assign rd_inc    = r_repeat_done + REPEAT_W'(1);
    assign codes_ok  = (i_address_code inside {[3'd1:3'd4]})
                    && (i_channel_code inside {[3'd1:3'd4]});

    always_comb begin
        if (!in_word) begin
            if (r_phase_high) begin
                phase_len = ONE_UNIT;
            end else begin
                phase_len = (r_protocol == PROTO_SHORT_SYNC) ? SYNC_SHORT : SYNC_LONG;
            end
        end else if (r_phase_high) begin
            phase_len = long_high ? LONG_UNITS : ONE_UNIT;
        end else begin
            phase_len = long_high ? ONE_UNIT : LONG_UNITS;
        end
    end

    always_comb begin
        n_code_word    = r_code_word;
        n_symbol_index = r_symbol_index;
        n_pulse_half   = r_pulse_half;
        n_phase_high   = r_phase_high;
        n_unit_count   = r_unit_count;
        n_tick_count   = r_tick_count;
        n_repeat_done  = r_repeat_done;
        n_active       = r_active;
        n_result       = '0;

        if (i_func == FUNC_START) begin
            if (r_active || !codes_ok) begin
                n_result.rejected = 1'b1;
            end else begin
                n_code_word    = {i_switch_on, 3'b111,
                                  group_bits(i_channel_code[1:0]),
                                  group_bits(i_address_code[1:0])};
                n_symbol_index = '0;
                n_pulse_half   = 1'b0;
                n_phase_high   = 1'b1;
                n_unit_count   = '0;
                n_tick_count   = '0;
                n_repeat_done  = '0;
                n_active       = 1'b1;
            end
            n_result.pin_level = n_active && n_phase_high;
            n_result.busy_res  = n_active;
        end else if (r_active) begin
            n_result.pin_level = r_phase_high;
            n_result.busy_res  = 1'b1;
            n_tick_count       = tick_inc;
            if (tick_inc >= pl || tick_inc == '0) begin
                n_tick_count = '0;
                n_unit_count = unit_inc;
                if (unit_inc >= phase_len || unit_inc == '0) begin
                    n_unit_count = '0;
                    if (r_phase_high) begin
                        n_phase_high = 1'b0;
                    end else begin
                        n_phase_high = 1'b1;
                        if (in_word) begin
                            if (!r_pulse_half) begin
                                n_pulse_half = 1'b1;
                            end else begin
                                n_pulse_half   = 1'b0;
                                n_symbol_index = r_symbol_index + SYM_IDX_W'(1);
                            end
                        end else begin
                            n_repeat_done  = rd_inc;
                            n_symbol_index = '0;
                            n_pulse_half   = 1'b0;
                            if (rd_inc >= limit || rd_inc == '0) begin
                                n_active      = 1'b0;
                                n_phase_high  = 1'b0;
                                n_repeat_done = '0;
                            end
                        end
                    end
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_length <= PULSE_RESET;
            r_repeat_count <= REPEAT_RESET;
            r_protocol     <= PROTO_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PULSE_LENGTH: r_pulse_length <= i_cfg_data;
                REG_REPEAT_COUNT: r_repeat_count <= i_cfg_data[REPEAT_W-1:0];
                REG_PROTOCOL:     r_protocol     <= i_cfg_data[PROTO_W-1:0];
                default:          ;
            endcase
        end
    end

    // waveform state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_word    <= '0;
            r_symbol_index <= '0;
            r_pulse_half   <= 1'b0;
            r_phase_high   <= 1'b0;
            r_unit_count   <= '0;
            r_tick_count   <= '0;
            r_repeat_done  <= '0;
            r_active       <= 1'b0;
        end else if (accept) begin
            r_code_word    <= n_code_word;
            r_symbol_index <= n_symbol_index;
            r_pulse_half   <= n_pulse_half;
            r_phase_high   <= n_phase_high;
            r_unit_count   <= n_unit_count;
            r_tick_count   <= n_tick_count;
            r_repeat_done  <= n_repeat_done;
            r_active       <= n_active;
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_result;
            end
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pin_level = r_out.pin_level;
    assign o_busy_res  = r_out.busy_res;
    assign o_rejected  = r_out.rejected;

endmodule

### rtl/trook_checker.sv
// port-level checks for the tri-state ook encoder and their bind
`timescale 1ns / 1ps

module trook_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_pin_level,
    input logic o_busy_res,
    input logic o_rejected
);

    // a keyed pin only goes high during a transmission
    a_pin_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pin_level |-> o_busy_res)
        else $error("pin high without busy");

    // input stalls only while a result waits in the output register
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // nothing pending after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result pending after reset");

    // a stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pin_level)
            && $stable(o_busy_res) && $stable(o_rejected))
        else $error("stalled output changed");

endmodule

bind tristate_ook_remote_switch_encoder_unit trook_checker u_trook_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pin_level (o_pin_level),
    .o_busy_res  (o_busy_res),
    .o_rejected  (o_rejected)
);

### tb/tb_tristate_ook_remote_switch_encoder_unit.sv
// self-checking testbench for the tri-state ook remote switch encoder unit
`timescale 1ns / 1ps

module tb_tristate_ook_remote_switch_encoder_unit;
    import trook_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam t_result NO_TX        = '{pin_level: 1'b0, busy_res: 1'b0, rejected: 1'b0};
    localparam t_result REFUSED_IDLE = '{pin_level: 1'b0, busy_res: 1'b0, rejected: 1'b1};
    localparam t_result SENDING_HIGH = '{pin_level: 1'b1, busy_res: 1'b1, rejected: 1'b0};
    localparam t_result REFUSED_BUSY = '{pin_level: 1'b1, busy_res: 1'b1, rejected: 1'b1};

    typedef struct packed {
        logic       typed;
        logic       func;
        logic [2:0] addr;
        logic [2:0] chan;
        logic       sw_on;
        t_result    want;
    } t_probe_row;

    localparam int N_PROBES = 14;

    // runs under the reset register values
    localparam t_probe_row PROBES [N_PROBES] = '{
        '{1'b1, FUNC_TICK,  3'd0, 3'd0, 1'b0, NO_TX},
        '{1'b1, FUNC_TICK,  3'd7, 3'd7, 1'b1, NO_TX},
        '{1'b1, FUNC_START, 3'd0, 3'd1, 1'b1, REFUSED_IDLE},
        '{1'b1, FUNC_START, 3'd5, 3'd2, 1'b0, REFUSED_IDLE},
        '{1'b1, FUNC_START, 3'd1, 3'd0, 1'b1, REFUSED_IDLE},
        '{1'b1, FUNC_START, 3'd2, 3'd7, 1'b0, REFUSED_IDLE},
        '{1'b1, FUNC_START, 3'd7, 3'd7, 1'b1, REFUSED_IDLE},
        '{1'b1, FUNC_START, 3'd0, 3'd0, 1'b0, REFUSED_IDLE},
        '{1'b1, FUNC_START, 3'd4, 3'd4, 1'b1, SENDING_HIGH},
        '{1'b1, FUNC_START, 3'd1, 3'd1, 1'b0, REFUSED_BUSY},
        '{1'b1, FUNC_TICK,  3'd3, 3'd6, 1'b1, SENDING_HIGH},
        '{1'b0, FUNC_TICK,  3'd0, 3'd0, 1'b0, NO_TX},
        '{1'b0, FUNC_START, 3'd3, 3'd2, 1'b1, NO_TX},
        '{1'b0, FUNC_TICK,  3'd5, 3'd1, 1'b0, NO_TX}
    };

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic                  i_func         = 1'b0;
    logic [2:0]            i_address_code = '0;
    logic [2:0]            i_channel_code = '0;
    logic                  i_switch_on    = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic                  o_pin_level;
    logic                  o_busy_res;
    logic                  o_rejected;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // predicted register values and waveform state
    logic [PULSE_W-1:0]   pulse_cfg  = PULSE_RESET;
    logic [REPEAT_W-1:0]  repeat_cfg = REPEAT_RESET;
    logic [PROTO_W-1:0]   proto_cfg  = PROTO_RESET;
    logic [SYMBOLS-1:0]   tri_flags  = '0;
    logic [SYM_IDX_W-1:0] sym_q      = '0;
    logic                 half_q     = 1'b0;
    logic                 high_q     = 1'b0;
    logic [UNIT_W-1:0]    units_q    = '0;
    logic [PULSE_W-1:0]   ticks_q    = '0;
    logic [REPEAT_W-1:0]  frames_q   = '0;
    logic                 active_q   = 1'b0;

    t_result keyer_out_q [$];
    int      errors     = 0;
    int      stall_hold = 0;

    tristate_ook_remote_switch_encoder_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_address_code (i_address_code),
        .i_channel_code (i_channel_code),
        .i_switch_on    (i_switch_on),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pin_level    (o_pin_level),
        .o_busy_res     (o_busy_res),
        .o_rejected     (o_rejected),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_result keyer_step(input logic f, input logic [2:0] a,
                                           input logic [2:0] c, input logic s);
        t_result             r;
        logic [PULSE_W-1:0]  unit_ticks;
        logic [UNIT_W-1:0]   phase_len;
        logic [REPEAT_W-1:0] frame_limit;
        logic                long_high;
        r = NO_TX;
        if (f == FUNC_START) begin
            if (active_q || a < 1 || a > 4 || c < 1 || c > 4) begin
                r.rejected = 1'b1;
            end else begin
                tri_flags = {s, 3'b111, 4'b1111 & ~(4'b0001 << (c - 3'd1)),
                             4'b1111 & ~(4'b0001 << (a - 3'd1))};
                sym_q    = '0;
                half_q   = 1'b0;
                high_q   = 1'b1;
                units_q  = '0;
                ticks_q  = '0;
                frames_q = '0;
                active_q = 1'b1;
            end
            r.pin_level = active_q && high_q;
            r.busy_res  = active_q;
            return r;
        end
        if (!active_q)
            return r;
        r.pin_level = high_q;
        r.busy_res  = 1'b1;
        unit_ticks  = (pulse_cfg == 0) ? PULSE_W'(1) : pulse_cfg;
        ticks_q     = ticks_q + 1'b1;
        if (ticks_q >= unit_ticks || ticks_q == 0) begin
            ticks_q = '0;
            units_q = units_q + 1'b1;
            if (sym_q >= SYMBOLS) begin
                phase_len = high_q ? ONE_UNIT
                          : (proto_cfg == PROTO_SHORT_SYNC) ? SYNC_SHORT : SYNC_LONG;
            end else begin
                long_high = tri_flags[sym_q] && half_q;
                phase_len = (high_q == long_high) ? LONG_UNITS : ONE_UNIT;
            end
            if (units_q >= phase_len || units_q == 0) begin
                units_q = '0;
                if (high_q) begin
                    high_q = 1'b0;
                end else begin
                    high_q = 1'b1;
                    if (sym_q < SYMBOLS) begin
                        if (!half_q) begin
                            half_q = 1'b1;
                        end else begin
                            half_q = 1'b0;
                            sym_q  = sym_q + 1'b1;
                        end
                    end else begin
                        frame_limit = (repeat_cfg == 0) ? REPEAT_W'(1) : repeat_cfg;
                        frames_q    = frames_q + 1'b1;
                        sym_q       = '0;
                        half_q      = 1'b0;
                        if (frames_q >= frame_limit || frames_q == 0) begin
                            active_q = 1'b0;
                            high_q   = 1'b0;
                            frames_q = '0;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic f, input logic [2:0] a, input logic [2:0] c,
                             input logic s, input logic typed, input t_result want);
        t_result r;
        i_in_valid     <= 1'b1;
        i_func         <= f;
        i_address_code <= a;
        i_channel_code <= c;
        i_switch_on    <= s;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        r = keyer_step(f, a, c, s);
        keyer_out_q.push_back(typed ? want : r);
    endtask

    task automatic idle_input(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // drain the pipeline, then write every register including the unused index
    task automatic apply_settings(input logic [PULSE_W-1:0] pl, input logic [REPEAT_W-1:0] rc,
                                  input logic [PROTO_W-1:0] pr);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        i_in_valid <= 1'b0;
        while (keyer_out_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_PULSE_LENGTH;
        i_cfg_data  <= pl;
        @(posedge i_clk);
        pulse_cfg   = pl;
        i_cfg_index <= REG_REPEAT_COUNT;
        i_cfg_data  <= {noise[15:8], rc};
        @(posedge i_clk);
        repeat_cfg  = rc;
        i_cfg_index <= REG_PROTOCOL;
        i_cfg_data  <= {noise[15:2], pr};
        @(posedge i_clk);
        proto_cfg   = pr;
        i_cfg_index <= REG_SPARE;
        i_cfg_data  <= noise;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input bit gappy);
        int         sent;
        int         roll;
        logic       f;
        logic [2:0] a;
        logic [2:0] c;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            f = (roll < (active_q ? 3 : 60)) ? FUNC_START : FUNC_TICK;
            if (f == FUNC_START && $urandom_range(0, 3) != 0) begin
                a = 3'($urandom_range(1, 4));
                c = 3'($urandom_range(1, 4));
            end else begin
                a = 3'($urandom_range(0, 7));
                c = 3'($urandom_range(0, 7));
            end
            if (f == FUNC_START || active_q)
                sent++;
            send_item(f, a, c, 1'($urandom_range(0, 1)), 1'b0, NO_TX);
            if (gappy)
                idle_input(gap_len());
        end
    endtask

    // output back-pressure: short stalls, a few long ones, and stall-free stretches
    always @(posedge i_clk) begin
        int roll;
        roll = $urandom_range(0, 99);
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (roll < 16) begin
            i_out_stall <= 1'b1;
            stall_hold  <= $urandom_range(0, 2);
        end else if (roll < 20) begin
            i_out_stall <= 1'b1;
            stall_hold  <= $urandom_range(10, 40);
        end else if (roll < 28) begin
            i_out_stall <= 1'b0;
            stall_hold  <= $urandom_range(40, 120);
        end else begin
            i_out_stall <= 1'b0;
            stall_hold  <= $urandom_range(0, 3);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (keyer_out_q.size() == 0) begin
                if (errors < 10)
                    $display("unexpected transaction: pin=%0b busy=%0b rej=%0b",
                             o_pin_level, o_busy_res, o_rejected);
                errors++;
            end else begin
                want = keyer_out_q.pop_front();
                if (o_pin_level !== want.pin_level || o_busy_res !== want.busy_res ||
                    o_rejected !== want.rejected) begin
                    if (errors < 10)
                        $display("mismatch: exp pin=%0b busy=%0b rej=%0b",
                                 want.pin_level, want.busy_res, want.rejected,
                                 ", got pin=%0b busy=%0b rej=%0b",
                                 o_pin_level, o_busy_res, o_rejected);
                    errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_PROBES; k++) begin
            send_item(PROBES[k].func, PROBES[k].addr, PROBES[k].chan, PROBES[k].sw_on,
                      PROBES[k].typed, PROBES[k].want);
            idle_input(gap_len());
        end

        apply_settings(16'd1, 8'd1, 2'd2);
        run_phase(140, 1'b0);
        apply_settings(16'd0, 8'd0, 2'd0);
        run_phase(80, 1'b1);
        apply_settings(16'd2, 8'd2, 2'd3);
        run_phase(40, 1'b1);
        apply_settings(16'hFFFF, 8'hFF, 2'd1);
        run_phase(20, 1'b1);
        apply_settings(16'd1, 8'd1, 2'd1);
        run_phase(110, 1'b1);
        apply_settings(16'd3, 8'd1, 2'd2);
        run_phase(60, 1'b1);

        i_in_valid <= 1'b0;
        for (int k = 0; k < 5000 && keyer_out_q.size() != 0; k++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        errors += keyer_out_q.size();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
